// ----- rtl/wdb_pkg.sv -----
// Shared types, widths and constants of the working-day counter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package wdb_pkg;

	localparam int DAY_W   = 5;
	localparam int MON_W   = 4;
	localparam int YEAR_W  = 14;
	localparam int MASK_W  = 7;
	localparam int WD_W    = 3;
	localparam int CNT_W   = 22;
	localparam int SER_W   = 23;
	localparam int Q100_W  = 8;
	localparam int MOFS_W  = 9;
	localparam int LEN_W   = 5;

	// Quotient by 100 as a reciprocal multiply, exact for every 14-bit value.
	localparam int                DIV100_SHIFT = 19;
	localparam logic [12:0]       DIV100_MUL   = 13'd5243;
	localparam int                PROD100_W    = YEAR_W + 13;

	// Quotient by 7 as a reciprocal multiply, exact for every 23-bit value.
	localparam int                DIV7_SHIFT = 28;
	localparam logic [25:0]       DIV7_MUL   = 26'd38347923;
	localparam int                PROD7_W    = SER_W + 26;
	localparam int                Q7_W       = PROD7_W - DIV7_SHIFT;

	// Serial counts from March 1 of year 0, which fell on a Wednesday.
	localparam logic [SER_W-1:0]  WD_OFFSET  = SER_W'(3);

	localparam logic [MASK_W-1:0] MASK_RESET = 7'h60;
	localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} wdb_adv_t;

	typedef struct packed {
		logic [CNT_W-1:0] working_days;
		logic [WD_W-1:0]  start_weekday;
		logic [WD_W-1:0]  end_weekday;
		logic             date_error;
	} wdb_res_t;

	// Days before the first of a month, months counted from March as 0.
	function automatic logic [MOFS_W-1:0] month_offset(input logic [MON_W-1:0] mm);
		logic [MOFS_W-1:0] ofs;
		unique case (mm)
			4'd0:    ofs = 9'd0;
			4'd1:    ofs = 9'd31;
			4'd2:    ofs = 9'd61;
			4'd3:    ofs = 9'd92;
			4'd4:    ofs = 9'd122;
			4'd5:    ofs = 9'd153;
			4'd6:    ofs = 9'd184;
			4'd7:    ofs = 9'd214;
			4'd8:    ofs = 9'd245;
			4'd9:    ofs = 9'd275;
			4'd10:   ofs = 9'd306;
			4'd11:   ofs = 9'd337;
			default: ofs = 9'd0;
		endcase
		return ofs;
	endfunction

	// Length of a calendar month; a month number outside 1 to 12 has none.
	function automatic logic [LEN_W-1:0] month_len(input logic [MON_W-1:0] m,
			input logic leap);
		logic [LEN_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                      len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/wdb_if.sv -----
// Valid/ready channel interfaces for queries and results of the counter.
// Depends on wdb_pkg for field widths.
`timescale 1ns / 1ps

interface wdb_query_if import wdb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DAY_W-1:0]  start_day;
	logic [MON_W-1:0]  start_month;
	logic [YEAR_W-1:0] start_year;
	logic [DAY_W-1:0]  end_day;
	logic [MON_W-1:0]  end_month;
	logic [YEAR_W-1:0] end_year;

	modport source (output valid, start_day, start_month, start_year,
		end_day, end_month, end_year, input ready);
	modport sink (input valid, start_day, start_month, start_year,
		end_day, end_month, end_year, output ready);
endinterface

interface wdb_result_if import wdb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] working_days;
	logic [WD_W-1:0]  start_weekday;
	logic [WD_W-1:0]  end_weekday;
	logic             date_error;

	modport source (output valid, working_days, start_weekday, end_weekday,
		date_error, input ready);
	modport sink (input valid, working_days, start_weekday, end_weekday,
		date_error, output ready);
endinterface

// ----- rtl/working_days_between_dates_top.sv -----
// Working-day counter between two Gregorian dates; uses wdb_pkg, wdb_if, wdb_date, wdb_count.
// A query passes through register stages s1 to s5 in order; its result is offered from s5.
// Throughput: one query per cycle through five register stages; each stage holds
// while the one after it is full and stalled, so bubbles are filled under back-pressure.
// Reset clears every stage valid bit and loads the weekend mask with Friday and Saturday.
`timescale 1ns / 1ps

module working_days_between_dates_top import wdb_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic              clk,
	input  logic              arst_n,
	wdb_query_if.sink         query,
	wdb_result_if.source      result,
	input  logic              cfg_we,
	input  logic [MASK_W-1:0] cfg_wdata
);

	logic [MASK_W-1:0] mask_q;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	wdb_adv_t          adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// A stage loads when it is empty or when the next stage loads too.
	always_comb begin
		adv.s5 = !v_s5 || result.ready;
		adv.s4 = !v_s4 || adv.s5;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign query.ready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= query.valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
		end
	end

	logic             start_ok_s2, end_ok_s2, start_ok_s4, end_ok_s4;
	logic [SER_W-1:0] start_serial_s2, end_serial_s2;
	logic [WD_W-1:0]  start_wd_s4, end_wd_s4;
	wdb_res_t         res_s5;

	wdb_date #(.MAX_YEAR(MAX_YEAR)) u_start (
		.clk        (clk),
		.adv        (adv),
		.day        (query.start_day),
		.month      (query.start_month),
		.year       (query.start_year),
		.ok_s2      (start_ok_s2),
		.serial_s2  (start_serial_s2),
		.ok_s4      (start_ok_s4),
		.weekday_s4 (start_wd_s4)
	);

	wdb_date #(.MAX_YEAR(MAX_YEAR)) u_end (
		.clk        (clk),
		.adv        (adv),
		.day        (query.end_day),
		.month      (query.end_month),
		.year       (query.end_year),
		.ok_s2      (end_ok_s2),
		.serial_s2  (end_serial_s2),
		.ok_s4      (end_ok_s4),
		.weekday_s4 (end_wd_s4)
	);

	wdb_count u_count (
		.clk             (clk),
		.adv             (adv),
		.mask            (mask_q),
		.start_ok_s2     (start_ok_s2),
		.end_ok_s2       (end_ok_s2),
		.start_serial_s2 (start_serial_s2),
		.end_serial_s2   (end_serial_s2),
		.start_ok_s4     (start_ok_s4),
		.end_ok_s4       (end_ok_s4),
		.start_wd_s4     (start_wd_s4),
		.end_wd_s4       (end_wd_s4),
		.res_s5          (res_s5)
	);

	assign result.valid         = v_s5;
	assign result.working_days  = res_s5.working_days;
	assign result.start_weekday = res_s5.start_weekday;
	assign result.end_weekday   = res_s5.end_weekday;
	assign result.date_error    = res_s5.date_error;

	// An invalid date never carries a nonzero count.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.date_error |-> result.working_days == '0)
		else $error("date error with nonzero working day count");

	// The weekday remainder stays in range.
	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.start_weekday != 3'd7) && (result.end_weekday != 3'd7))
		else $error("weekday out of range");

	// A full, stalled pipeline takes no new query.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !result.ready |-> !query.ready)
		else $error("query taken while pipeline full and stalled");

	// Every query transfer occupies the first stage on the next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		query.valid && query.ready |=> v_s1)
		else $error("transferred query lost at stage one");

endmodule

// ----- rtl/wdb_date.sv -----
// Per-date pipeline: validity check, day serial and weekday of one date.
// Depends on wdb_pkg; stepped by the stage enables of the top level.
`timescale 1ns / 1ps

module wdb_date import wdb_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic              clk,
	input  wdb_adv_t          adv,
	input  logic [DAY_W-1:0]  day,
	input  logic [MON_W-1:0]  month,
	input  logic [YEAR_W-1:0] year,
	output logic              ok_s2,
	output logic [SER_W-1:0]  serial_s2,
	output logic              ok_s4,
	output logic [WD_W-1:0]   weekday_s4
);

	localparam logic [YEAR_W:0] YEAR_CAP = (YEAR_W+1)'(MAX_YEAR);

	// Stage 1: shift January and February to the end of the previous year.
	logic                 jan_feb;
	logic [YEAR_W-1:0]    yy;
	logic [MON_W-1:0]     mm;
	logic [PROD100_W-1:0] prod_y;
	logic [PROD100_W-1:0] prod_yy;

	logic [DAY_W-1:0]  day_s1;
	logic [MON_W-1:0]  month_s1;
	logic [YEAR_W-1:0] year_s1;
	logic [YEAR_W-1:0] yy_s1;
	logic [MON_W-1:0]  mm_s1;
	logic [Q100_W-1:0] qy_s1;
	logic [Q100_W-1:0] qyy_s1;

	always_comb begin
		jan_feb = (month <= MON_W'(2));
		yy      = year - YEAR_W'(jan_feb);
		mm      = jan_feb ? month + MON_W'(9) : month - MON_W'(3);
		prod_y  = PROD100_W'(year) * PROD100_W'(DIV100_MUL);
		prod_yy = PROD100_W'(yy) * PROD100_W'(DIV100_MUL);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			day_s1   <= day;
			month_s1 <= month;
			year_s1  <= year;
			yy_s1    <= yy;
			mm_s1    <= mm;
			qy_s1    <= prod_y[DIV100_SHIFT +: Q100_W];
			qyy_s1   <= prod_yy[DIV100_SHIFT +: Q100_W];
		end
	end

	// Stage 2: leap year, month length, range checks and the day serial.
	logic              cent;
	logic              leap;
	logic [LEN_W-1:0]  len;
	logic              ok;
	logic [SER_W-1:0]  serial;

	always_comb begin
		cent = (year_s1 == YEAR_W'(YEAR_W'(qy_s1) * YEAR_W'(100)));
		leap = cent ? (qy_s1[1:0] == 2'b00) : (year_s1[1:0] == 2'b00);
		len  = month_len(month_s1, leap);
		ok   = (year_s1 != '0) && ({1'b0, year_s1} <= YEAR_CAP)
			&& (day_s1 != '0) && (day_s1 <= len);
		serial = SER_W'(yy_s1) * SER_W'(365) + SER_W'(yy_s1 >> 2)
			- SER_W'(qyy_s1) + SER_W'(qyy_s1 >> 2)
			+ SER_W'(month_offset(mm_s1)) + SER_W'(day_s1) - SER_W'(1);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			ok_s2     <= ok;
			serial_s2 <= serial;
		end
	end

	// Stage 3: quotient of the shifted serial by seven.
	logic [SER_W-1:0]   sp3;
	logic [PROD7_W-1:0] prod7;
	logic               ok_s3;
	logic [SER_W-1:0]   sp3_s3;
	logic [Q7_W-1:0]    q7_s3;

	always_comb begin
		sp3   = serial_s2 + WD_OFFSET;
		prod7 = PROD7_W'(sp3) * PROD7_W'(DIV7_MUL);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			ok_s3  <= ok_s2;
			sp3_s3 <= sp3;
			q7_s3  <= prod7[PROD7_W-1:DIV7_SHIFT];
		end
	end

	// Stage 4: the remainder is below seven, so s - 7q equals s + q modulo 8.
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			ok_s4      <= ok_s3;
			weekday_s4 <= ok_s3 ? WD_W'(sp3_s3[WD_W-1:0] + q7_s3[WD_W-1:0]) : '0;
		end
	end

endmodule

// ----- rtl/wdb_count.sv -----
// Day difference, whole weeks and partial week, and the result register.
// Depends on wdb_pkg; fed by the two wdb_date pipelines.
`timescale 1ns / 1ps

module wdb_count import wdb_pkg::*; (
	input  logic              clk,
	input  wdb_adv_t          adv,
	input  logic [MASK_W-1:0] mask,
	input  logic              start_ok_s2,
	input  logic              end_ok_s2,
	input  logic [SER_W-1:0]  start_serial_s2,
	input  logic [SER_W-1:0]  end_serial_s2,
	input  logic              start_ok_s4,
	input  logic              end_ok_s4,
	input  logic [WD_W-1:0]   start_wd_s4,
	input  logic [WD_W-1:0]   end_wd_s4,
	output wdb_res_t          res_s5
);

	localparam int BASE_W = Q7_W + WD_W;

	// Stage 3: span in days and its quotient by seven.
	logic [SER_W-1:0]   span;
	logic [PROD7_W-1:0] prod7;
	logic               pos_s3;
	logic [SER_W-1:0]   span_s3;
	logic [Q7_W-1:0]    weeks_s3;

	always_comb begin
		span  = end_serial_s2 - start_serial_s2;
		prod7 = PROD7_W'(span) * PROD7_W'(DIV7_MUL);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			pos_s3   <= start_ok_s2 && end_ok_s2 && (end_serial_s2 > start_serial_s2);
			span_s3  <= span;
			weeks_s3 <= prod7[PROD7_W-1:DIV7_SHIFT];
		end
	end

	// Stage 4: leftover days and the number of working weekdays per week.
	logic [WD_W-1:0] marked;
	logic            pos_s4;
	logic [Q7_W-1:0] weeks_s4;
	logic [WD_W-1:0] rem_s4;
	logic [WD_W-1:0] free_s4;

	always_comb begin
		marked = '0;
		for (int k = 0; k < MASK_W; k++) begin
			marked = marked + WD_W'(mask[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			pos_s4   <= pos_s3;
			weeks_s4 <= weeks_s3;
			rem_s4   <= WD_W'(span_s3[WD_W-1:0] + weeks_s3[WD_W-1:0]);
			free_s4  <= WD_W'(3'd7 - marked);
		end
	end

	// Stage 5: whole weeks times free days plus the partial week from the start weekday.
	logic [WD_W-1:0]   partial;
	logic [WD_W:0]     wd_sum;
	logic [BASE_W-1:0] total;
	logic [CNT_W-1:0]  count;

	always_comb begin
		partial = '0;
		for (int k = 0; k < MASK_W; k++) begin
			wd_sum = (WD_W+1)'(start_wd_s4) + (WD_W+1)'(k);
			if (wd_sum >= (WD_W+1)'(7)) begin
				wd_sum = wd_sum - (WD_W+1)'(7);
			end
			if ((WD_W'(k) < rem_s4) && !mask[wd_sum[WD_W-1:0]]) begin
				partial = partial + WD_W'(1);
			end
		end
		total = BASE_W'(weeks_s4) * BASE_W'(free_s4) + BASE_W'(partial);
		if (!pos_s4) begin
			count = '0;
		end else if (total > BASE_W'(COUNT_MAX)) begin
			count = COUNT_MAX;
		end else begin
			count = total[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			res_s5.working_days  <= count;
			res_s5.start_weekday <= start_wd_s4;
			res_s5.end_weekday   <= end_wd_s4;
			res_s5.date_error    <= !(start_ok_s4 && end_ok_s4);
		end
	end

endmodule
